FILE: hw/rtl/swarq_pkg.sv
// Shared definitions for the stop-and-wait ARQ sender: opcodes, result kinds,
// register indexes, reset values and sizing constants. No dependencies.
package swarq_pkg;

  // Default sizing of the descriptor queue and the buffer handle.
  localparam int QUEUE_DEPTH_DEFAULT  = 16;
  localparam int HANDLE_WIDTH_DEFAULT = 8;

  // Result queue between the event logic and the output channel.
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_IDXW  = 2;

  // Input opcodes.
  localparam logic [2:0] OP_ENQUEUE     = 3'd0;
  localparam logic [2:0] OP_ACK         = 3'd1;
  localparam logic [2:0] OP_NACK        = 3'd2;
  localparam logic [2:0] OP_TICK        = 3'd3;
  localparam logic [2:0] OP_LINK_STATUS = 3'd4;
  localparam logic [2:0] OP_CLOSE       = 3'd5;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_ACCEPTED = 3'd0,
    KIND_REJECTED = 3'd1,
    KIND_SEND     = 3'd2,
    KIND_ACKED    = 3'd3,
    KIND_FAILED   = 3'd4
  } kind_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LINK_OPEN         = 3'd0;
  localparam logic [2:0] CFG_RETRY_TIMEOUT     = 3'd1;
  localparam logic [2:0] CFG_NACK_BACKOFF      = 3'd2;
  localparam logic [2:0] CFG_RETRY_LIMIT       = 3'd3;
  localparam logic [2:0] CFG_MAX_FRAME_PAYLOAD = 3'd4;

  // Register reset values.
  localparam logic [15:0] RETRY_TIMEOUT_RESET     = 16'd1000;
  localparam logic [15:0] NACK_BACKOFF_RESET      = 16'd250;
  localparam logic [7:0]  RETRY_LIMIT_RESET       = 8'd5;
  localparam logic [15:0] MAX_FRAME_PAYLOAD_RESET = 16'd1024;

  // Acknowledgement length classes.
  localparam logic [1:0] ACK_LEN_EMPTY = 2'd0;
  localparam logic [1:0] ACK_LEN_FOUR  = 2'd1;

  // Bytes of sequence number carried in each frame payload.
  localparam logic [16:0] FRAME_OVERHEAD = 17'd4;

  // Device state code that means connected.
  localparam logic [7:0] LINK_CONNECTED = 8'd3;

  // First sequence number of a flow.
  localparam logic [31:0] SEQUENCE_START = 32'd1;

endpackage

FILE: hw/rtl/swarq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the descriptor queue of the ARQ sender. No dependencies.
module swarq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/stop_and_wait_arq_sender_core.sv
// Stop-and-wait ARQ sender core: descriptor queue, in-flight frame, retry timer.
// Depends on swarq_pkg and instantiates swarq_ram for the descriptor queue.
//
// The block takes one event transfer per clock cycle while in_ready is high
// (enqueue, ACK, NACK, tick, link status or close) and produces zero, one or
// two result transfers for it, with last set on the final one. Each event is
// handled by combinational logic between the input handshake and a four-entry
// result queue, so a new event can be accepted in every cycle while earlier
// results still wait to be taken. The output side drains one result per cycle
// while out_ready is high, which sets the sustained rate: events that cause no
// result or one result run at one per cycle, and those that cause two (an
// enqueue or ACK that starts a frame) take twice the output bandwidth. in_ready
// falls while fewer than two result slots are free. Payload descriptors are
// held in a RAM of QUEUE_DEPTH entries; the entry at the head is read ahead of
// time so that it is ready when a frame starts, and an entry written in the same
// cycle that it becomes the head is bypassed. Configuration writes take effect
// on the next clock edge and should only be made while the block is idle.
module stop_and_wait_arq_sender_core #(
  parameter int QUEUE_DEPTH  = swarq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int HANDLE_WIDTH = swarq_pkg::HANDLE_WIDTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,

  // Configuration write port.
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_data,

  // Event channel.
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              opcode,
  input  logic [HANDLE_WIDTH-1:0] buffer_handle,
  input  logic [15:0]             buffer_length,
  input  logic [31:0]             ack_sequence,
  input  logic [1:0]              ack_length_class,
  input  logic [7:0]              link_state,

  // Result channel.
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              result_kind,
  output logic [31:0]             frame_sequence,
  output logic [HANDLE_WIDTH-1:0] frame_handle,
  output logic [15:0]             frame_length,
  output logic                    last
);

  localparam int IDXW  = $clog2(QUEUE_DEPTH);
  localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUMW  = $clog2(2 * QUEUE_DEPTH);
  localparam int ENTW  = HANDLE_WIDTH + 16;
  localparam int OFIFO_IDXW = swarq_pkg::OFIFO_IDXW;

  typedef struct packed {
    logic [HANDLE_WIDTH-1:0] handle;
    logic [15:0]             length;
  } entry_t;

  typedef struct packed {
    swarq_pkg::kind_t        kind;
    logic [31:0]             seqn;
    logic [HANDLE_WIDTH-1:0] handle;
    logic [15:0]             length;
    logic                    last;
  } res_t;

  // Configuration registers.
  logic        link_open;
  logic [15:0] retry_timeout;
  logic [15:0] nack_backoff;
  logic [7:0]  retry_limit;
  logic [15:0] max_frame_payload;

  // Flow state.
  logic [IDXW-1:0]         queue_head, queue_head_next;
  logic [CNTW-1:0]         queue_count, queue_count_next;
  logic                    inflight_valid, inflight_valid_next;
  logic [HANDLE_WIDTH-1:0] inflight_handle, inflight_handle_next;
  logic [15:0]             inflight_length, inflight_length_next;
  logic [31:0]             inflight_sequence, inflight_sequence_next;
  logic [31:0]             next_sequence, next_sequence_next;
  logic [7:0]              retry_count, retry_count_next;
  logic [15:0]             timer_remaining, timer_remaining_next;
  logic                    timer_running, timer_running_next;

  // Descriptor queue access.
  logic            ram_we;
  logic [IDXW-1:0] queue_tail;
  logic [SUMW-1:0] tail_sum;
  entry_t          ram_wdata;
  entry_t          ram_rdata;
  logic            bypass;
  entry_t          bypass_data;
  entry_t          head_entry;
  entry_t          pump_entry;

  // Event decode and results.
  logic            in_fire;
  logic            enq_reject;
  logic            seq_match;
  logic            do_pump;
  res_t            res0;
  res_t            res1;
  res_t            send_res;
  logic [1:0]      res_count;

  // Result queue.
  res_t                  ofifo [swarq_pkg::OFIFO_DEPTH];
  logic [OFIFO_IDXW-1:0] ohead;
  logic [OFIFO_IDXW-1:0] otail;
  logic [OFIFO_IDXW:0]   ocount;
  logic                  out_fire;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      link_open         <= 1'b0;
      retry_timeout     <= swarq_pkg::RETRY_TIMEOUT_RESET;
      nack_backoff      <= swarq_pkg::NACK_BACKOFF_RESET;
      retry_limit       <= swarq_pkg::RETRY_LIMIT_RESET;
      max_frame_payload <= swarq_pkg::MAX_FRAME_PAYLOAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swarq_pkg::CFG_LINK_OPEN:         link_open         <= cfg_data[0];
        swarq_pkg::CFG_RETRY_TIMEOUT:     retry_timeout     <= cfg_data;
        swarq_pkg::CFG_NACK_BACKOFF:      nack_backoff      <= cfg_data;
        swarq_pkg::CFG_RETRY_LIMIT:       retry_limit       <= cfg_data[7:0];
        swarq_pkg::CFG_MAX_FRAME_PAYLOAD: max_frame_payload <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Descriptor queue. The RAM is read at the head position of the next cycle,
  // so head_entry always shows the current head. A write that lands on that
  // position in the same cycle is not yet visible in the RAM output and is
  // taken from the bypass register instead.
  // ---------------------------------------------------------------------------
  assign tail_sum   = SUMW'(queue_head) + SUMW'(queue_count);
  assign queue_tail = (tail_sum >= SUMW'(QUEUE_DEPTH)) ?
                      IDXW'(tail_sum - SUMW'(QUEUE_DEPTH)) : IDXW'(tail_sum);

  assign ram_wdata.handle = buffer_handle;
  assign ram_wdata.length = buffer_length;

  swarq_ram #(
    .WIDTH (ENTW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (queue_tail),
    .wdata (ram_wdata),
    .raddr (queue_head_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b0;
    end else begin
      bypass <= ram_we && (queue_tail == queue_head_next);
    end
    bypass_data <= ram_wdata;
  end

  assign head_entry = bypass ? bypass_data : ram_rdata;

  // An enqueue into an empty queue with no frame in flight is popped in the same
  // cycle, straight from the input fields.
  assign pump_entry = (queue_count == '0) ? ram_wdata : head_entry;

  // ---------------------------------------------------------------------------
  // Event handling.
  // ---------------------------------------------------------------------------
  assign in_ready = (ocount <= (OFIFO_IDXW + 1)'(swarq_pkg::OFIFO_DEPTH - 2));
  assign in_fire  = in_valid && in_ready;

  assign enq_reject = !link_open || (buffer_length == 16'd0)
                   || (({1'b0, buffer_length} + swarq_pkg::FRAME_OVERHEAD)
                       > {1'b0, max_frame_payload})
                   || (queue_count == CNTW'(QUEUE_DEPTH));

  assign seq_match = (ack_sequence == inflight_sequence);

  // The result that starts a new frame carries the fields the pump loads.
  always_comb begin
    send_res        = '0;
    send_res.kind   = swarq_pkg::KIND_SEND;
    send_res.seqn   = next_sequence;
    send_res.handle = pump_entry.handle;
    send_res.length = pump_entry.length;
  end

  always_comb begin
    queue_head_next        = queue_head;
    queue_count_next       = queue_count;
    inflight_valid_next    = inflight_valid;
    inflight_handle_next   = inflight_handle;
    inflight_length_next   = inflight_length;
    inflight_sequence_next = inflight_sequence;
    next_sequence_next     = next_sequence;
    retry_count_next       = retry_count;
    timer_remaining_next   = timer_remaining;
    timer_running_next     = timer_running;
    ram_we                 = 1'b0;
    do_pump                = 1'b0;
    res0                   = '0;
    res1                   = '0;
    res_count              = 2'd0;

    if (in_fire) begin
      unique case (opcode)
        swarq_pkg::OP_ENQUEUE: begin
          if (enq_reject) begin
            res0.kind = swarq_pkg::KIND_REJECTED;
            res0.last = 1'b1;
            res_count = 2'd1;
          end else begin
            ram_we           = 1'b1;
            queue_count_next = queue_count + CNTW'(1);
            if (!inflight_valid) begin
              do_pump   = 1'b1;
              res0      = send_res;
              res1.kind = swarq_pkg::KIND_ACCEPTED;
              res1.last = 1'b1;
              res_count = 2'd2;
            end else begin
              res0.kind = swarq_pkg::KIND_ACCEPTED;
              res0.last = 1'b1;
              res_count = 2'd1;
            end
          end
        end

        swarq_pkg::OP_ACK: begin
          if ((ack_length_class == swarq_pkg::ACK_LEN_FOUR) && inflight_valid
              && seq_match) begin
            timer_running_next   = 1'b0;
            timer_remaining_next = 16'd0;
            inflight_valid_next  = 1'b0;
            retry_count_next     = 8'd0;
            if (link_open && (queue_count != '0)) begin
              do_pump   = 1'b1;
              res0      = send_res;
              res1.kind = swarq_pkg::KIND_ACKED;
              res1.last = 1'b1;
              res_count = 2'd2;
            end else begin
              res0.kind = swarq_pkg::KIND_ACKED;
              res0.last = 1'b1;
              res_count = 2'd1;
            end
          end
        end

        swarq_pkg::OP_NACK: begin
          if (inflight_valid && ((ack_length_class == swarq_pkg::ACK_LEN_EMPTY)
              || ((ack_length_class == swarq_pkg::ACK_LEN_FOUR) && seq_match))) begin
            timer_remaining_next = nack_backoff;
            timer_running_next   = 1'b1;
          end
        end

        swarq_pkg::OP_TICK: begin
          if (link_open && timer_running) begin
            if (timer_remaining > 16'd1) begin
              timer_remaining_next = timer_remaining - 16'd1;
            end else begin
              timer_remaining_next = 16'd0;
              timer_running_next   = 1'b0;
              if (inflight_valid) begin
                if (retry_count >= retry_limit) begin
                  queue_head_next     = '0;
                  queue_count_next    = '0;
                  inflight_valid_next = 1'b0;
                  retry_count_next    = 8'd0;
                  res0.kind           = swarq_pkg::KIND_FAILED;
                  res0.last           = 1'b1;
                  res_count           = 2'd1;
                end else begin
                  retry_count_next     = retry_count + 8'd1;
                  timer_remaining_next = retry_timeout;
                  timer_running_next   = 1'b1;
                  res0.kind            = swarq_pkg::KIND_SEND;
                  res0.seqn            = inflight_sequence;
                  res0.handle          = inflight_handle;
                  res0.length          = inflight_length;
                  res0.last            = 1'b1;
                  res_count            = 2'd1;
                end
              end
            end
          end
        end

        swarq_pkg::OP_LINK_STATUS: begin
          if (link_state != swarq_pkg::LINK_CONNECTED) begin
            queue_head_next      = '0;
            queue_count_next     = '0;
            inflight_valid_next  = 1'b0;
            retry_count_next     = 8'd0;
            timer_remaining_next = 16'd0;
            timer_running_next   = 1'b0;
          end
        end

        swarq_pkg::OP_CLOSE: begin
          queue_head_next      = '0;
          queue_count_next     = '0;
          inflight_valid_next  = 1'b0;
          retry_count_next     = 8'd0;
          timer_remaining_next = 16'd0;
          timer_running_next   = 1'b0;
          next_sequence_next   = swarq_pkg::SEQUENCE_START;
        end

        default: begin
        end
      endcase

      // Starting a frame pops the head descriptor and arms the retry timer.
      if (do_pump) begin
        queue_head_next        = (queue_head == IDXW'(QUEUE_DEPTH - 1)) ?
                                 '0 : queue_head + IDXW'(1);
        queue_count_next       = queue_count_next - CNTW'(1);
        inflight_valid_next    = 1'b1;
        inflight_handle_next   = pump_entry.handle;
        inflight_length_next   = pump_entry.length;
        inflight_sequence_next = next_sequence;
        next_sequence_next     = next_sequence + 32'd1;
        retry_count_next       = 8'd0;
        timer_remaining_next   = retry_timeout;
        timer_running_next     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_head      <= '0;
      queue_count     <= '0;
      inflight_valid  <= 1'b0;
      next_sequence   <= swarq_pkg::SEQUENCE_START;
      retry_count     <= 8'd0;
      timer_remaining <= 16'd0;
      timer_running   <= 1'b0;
    end else begin
      queue_head      <= queue_head_next;
      queue_count     <= queue_count_next;
      inflight_valid  <= inflight_valid_next;
      next_sequence   <= next_sequence_next;
      retry_count     <= retry_count_next;
      timer_remaining <= timer_remaining_next;
      timer_running   <= timer_running_next;
    end
    inflight_handle   <= inflight_handle_next;
    inflight_length   <= inflight_length_next;
    inflight_sequence <= inflight_sequence_next;
  end

  // ---------------------------------------------------------------------------
  // Result queue. Up to two results are written per accepted event and one is
  // presented on the output channel each cycle while the queue is not empty.
  // ---------------------------------------------------------------------------
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ohead  <= '0;
      otail  <= '0;
      ocount <= '0;
    end else begin
      ohead  <= ohead + OFIFO_IDXW'(out_fire);
      otail  <= otail + OFIFO_IDXW'(res_count);
      ocount <= ocount + (OFIFO_IDXW + 1)'(res_count)
                       - (OFIFO_IDXW + 1)'(out_fire);
    end
    if (res_count != 2'd0) begin
      ofifo[otail] <= res0;
    end
    if (res_count == 2'd2) begin
      ofifo[otail + OFIFO_IDXW'(1)] <= res1;
    end
  end

  assign out_valid      = (ocount != '0);
  assign result_kind    = ofifo[ohead].kind;
  assign frame_sequence = ofifo[ohead].seqn;
  assign frame_handle   = ofifo[ohead].handle;
  assign frame_length   = ofifo[ohead].length;
  assign last           = ofifo[ohead].last;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // The retry timer only runs while a frame is outstanding.
  a_timer_needs_frame: assert property (@(posedge clk) disable iff (rst)
    timer_running |-> inflight_valid)
    else $error("retry timer running with no frame in flight");

  // The descriptor queue never holds more entries than it has.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    queue_count <= CNTW'(QUEUE_DEPTH))
    else $error("descriptor queue count beyond its depth");

  // The result queue never overflows.
  a_ofifo_bound: assert property (@(posedge clk) disable iff (rst)
    ocount <= (OFIFO_IDXW + 1)'(swarq_pkg::OFIFO_DEPTH))
    else $error("result queue overflow");

  // A frame only goes into flight together with a send-frame result.
  a_start_reports_send: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !inflight_valid && inflight_valid_next)
      |-> (res_count != 2'd0) && (res0.kind == swarq_pkg::KIND_SEND))
    else $error("frame started without a send-frame result");

endmodule

FILE: tb/sv/swarq_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the stop-and-wait ARQ sender core: mirrors register writes,
// predicts the results of every event transfer and compares them with the output.
// Depends on swarq_pkg.
module swarq_result_checker #(
  parameter int QUEUE_DEPTH  = swarq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int HANDLE_WIDTH = swarq_pkg::HANDLE_WIDTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [2:0]              opcode,
  input  logic [HANDLE_WIDTH-1:0] buffer_handle,
  input  logic [15:0]             buffer_length,
  input  logic [31:0]             ack_sequence,
  input  logic [1:0]              ack_length_class,
  input  logic [7:0]              link_state,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [2:0]              result_kind,
  input  logic [31:0]             frame_sequence,
  input  logic [HANDLE_WIDTH-1:0] frame_handle,
  input  logic [15:0]             frame_length,
  input  logic                    last,
  output int                      mismatch_count,
  output int                      awaited_count
);
  import swarq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);

  typedef struct {
    kind_t                   kind;
    logic [31:0]             seq_no;
    logic [HANDLE_WIDTH-1:0] buf_h;
    logic [15:0]             len;
    logic                    last;
  } frame_result_t;

  // Register mirror.
  logic        port_open;
  logic [15:0] resend_ticks;
  logic [15:0] backoff_ticks;
  logic [7:0]  resend_limit;
  logic [15:0] payload_cap;

  // Sender state.
  logic [HANDLE_WIDTH-1:0] desc_handle [QUEUE_DEPTH];
  logic [15:0]             desc_len    [QUEUE_DEPTH];
  logic [IW-1:0]           desc_head;
  logic [IW:0]             desc_count;
  logic                    fl_valid;
  logic [HANDLE_WIDTH-1:0] fl_handle;
  logic [15:0]             fl_len;
  logic [31:0]             fl_seq;
  logic [31:0]             seq_next;
  logic [7:0]              resends;
  logic [15:0]             timer_left;
  logic                    timer_on;

  frame_result_t batch[$];
  frame_result_t awaited[$];
  frame_result_t want;

  initial mismatch_count = 0;
  initial awaited_count = 0;

  function void note(kind_t k, bit with_frame);
    frame_result_t r;
    r.kind   = k;
    r.seq_no = with_frame ? fl_seq : '0;
    r.buf_h  = with_frame ? fl_handle : '0;
    r.len    = with_frame ? fl_len : '0;
    r.last   = 1'b0;
    batch.push_back(r);
  endfunction

  function void arm_timer(logic [15:0] ticks);
    timer_left = ticks;
    timer_on   = 1'b1;
  endfunction

  function void clear_flow();
    timer_on   = 1'b0;
    timer_left = '0;
    desc_head  = '0;
    desc_count = '0;
    fl_valid   = 1'b0;
    resends    = '0;
  endfunction

  // Pops the head descriptor into flight when the port allows it.
  function void start_next();
    if (!port_open || fl_valid || desc_count == 0) return;
    fl_handle = desc_handle[desc_head];
    fl_len    = desc_len[desc_head];
    desc_head = (int'(desc_head) == QUEUE_DEPTH - 1) ? '0 : desc_head + 1'b1;
    desc_count = desc_count - 1'b1;
    fl_valid  = 1'b1;
    fl_seq    = seq_next;
    seq_next  = seq_next + 1;
    resends   = '0;
    note(KIND_SEND, 1'b1);
    arm_timer(resend_ticks);
  endfunction

  function void advance_sender(logic [2:0] op, logic [HANDLE_WIDTH-1:0] h, logic [15:0] l,
                               logic [31:0] s, logic [1:0] c, logic [7:0] ls);
    int tail;
    batch.delete();
    case (op)
      OP_ENQUEUE: begin
        if (!port_open || l == 0 || ({1'b0, l} + FRAME_OVERHEAD) > {1'b0, payload_cap}
            || desc_count >= QUEUE_DEPTH) begin
          note(KIND_REJECTED, 1'b0);
        end else begin
          tail = (int'(desc_head) + int'(desc_count)) % QUEUE_DEPTH;
          desc_handle[tail] = h;
          desc_len[tail]    = l;
          desc_count = desc_count + 1'b1;
          start_next();
          note(KIND_ACCEPTED, 1'b0);
        end
      end
      OP_ACK: begin
        if (c == ACK_LEN_FOUR && fl_valid && s == fl_seq) begin
          timer_on   = 1'b0;
          timer_left = '0;
          fl_valid   = 1'b0;
          resends    = '0;
          start_next();
          note(KIND_ACKED, 1'b0);
        end
      end
      OP_NACK: begin
        if (fl_valid && (c == ACK_LEN_EMPTY || (c == ACK_LEN_FOUR && s == fl_seq)))
          arm_timer(backoff_ticks);
      end
      OP_TICK: begin
        if (port_open && timer_on) begin
          if (timer_left > 16'd1) begin
            timer_left = timer_left - 1'b1;
          end else begin
            timer_left = '0;
            timer_on   = 1'b0;
            if (fl_valid) begin
              if (resends >= resend_limit) begin
                clear_flow();
                note(KIND_FAILED, 1'b0);
              end else begin
                resends = resends + 1'b1;
                note(KIND_SEND, 1'b1);
                arm_timer(resend_ticks);
              end
            end
          end
        end
      end
      OP_LINK_STATUS: begin
        if (ls != LINK_CONNECTED) clear_flow();
      end
      OP_CLOSE: begin
        clear_flow();
        seq_next = SEQUENCE_START;
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) awaited.push_back(batch[i]);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      port_open     = 1'b0;
      resend_ticks  = RETRY_TIMEOUT_RESET;
      backoff_ticks = NACK_BACKOFF_RESET;
      resend_limit  = RETRY_LIMIT_RESET;
      payload_cap   = MAX_FRAME_PAYLOAD_RESET;
      clear_flow();
      fl_handle = '0;
      fl_len    = '0;
      fl_seq    = '0;
      seq_next  = SEQUENCE_START;
      awaited.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINK_OPEN:         port_open     = cfg_data[0];
          CFG_RETRY_TIMEOUT:     resend_ticks  = cfg_data;
          CFG_NACK_BACKOFF:      backoff_ticks = cfg_data;
          CFG_RETRY_LIMIT:       resend_limit  = cfg_data[7:0];
          CFG_MAX_FRAME_PAYLOAD: payload_cap   = cfg_data;
          default: ;
        endcase
      end
      // Results of an event can only leave after the edge that took it, so the
      // prediction is made before the output of this edge is compared.
      if (in_valid && in_ready)
        advance_sender(opcode, buffer_handle, buffer_length, ack_sequence,
                       ack_length_class, link_state);
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("checker: unexpected result kind %0d seq %0d handle %0d len %0d last %0d",
                     result_kind, frame_sequence, frame_handle, frame_length, last);
        end else begin
          want = awaited.pop_front();
          if (result_kind !== want.kind || frame_sequence !== want.seq_no
              || frame_handle !== want.buf_h || frame_length !== want.len
              || last !== want.last) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
              $display("checker: expected kind %0d seq %0d handle %0d len %0d last %0d",
                       want.kind, want.seq_no, want.buf_h, want.len, want.last);
              $display("checker: actual   kind %0d seq %0d handle %0d len %0d last %0d",
                       result_kind, frame_sequence, frame_handle, frame_length, last);
            end
          end
        end
      end
    end
    awaited_count = awaited.size();
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top level of the stop-and-wait ARQ sender testbench: clock, reset, stimulus
// and verdict. Depends on swarq_pkg, stop_and_wait_arq_sender_core and
// swarq_result_checker.
module tb;
  import swarq_pkg::*;

  // Cycles without any transfer on either channel before the run is abandoned.
  // The longest correct quiet spell is a long output stall on top of a long
  // input gap and a settling pause.
  localparam int WATCHDOG_LIMIT = 2000;
  // The core writes the results of each event into its result queue as it takes
  // the event, so this pause after the last result is ample before a register write.
  localparam int SETTLE_CYCLES  = 8;
  // Opcodes outside the defined set; the core must ignore them.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  logic        clk;
  logic        rst              = 1'b1;
  logic        cfg_we           = 1'b0;
  logic [2:0]  cfg_index        = CFG_LINK_OPEN;
  logic [15:0] cfg_data         = '0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode           = OP_ENQUEUE;
  logic [7:0]  buffer_handle    = '0;
  logic [15:0] buffer_length    = '0;
  logic [31:0] ack_sequence     = '0;
  logic [1:0]  ack_length_class = ACK_LEN_EMPTY;
  logic [7:0]  link_state       = LINK_CONNECTED;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [2:0]  result_kind;
  logic [31:0] frame_sequence;
  logic [7:0]  frame_handle;
  logic [15:0] frame_length;
  logic        last;

  int          mismatch_count;
  int          awaited_count;

  // Sequence number of the most recent frame seen leaving the core. Most
  // acknowledgements quote it, so that frames really complete.
  logic [31:0] last_sent   = SEQUENCE_START;
  // Mirror of the payload limit, used to aim lengths at the acceptance edge.
  logic [15:0] cur_cap     = MAX_FRAME_PAYLOAD_RESET;
  int          idle_cycles = 0;
  int          in_calm     = 0;
  int          stall_left  = 0;
  int          out_calm    = 0;
  int          pick;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  stop_and_wait_arq_sender_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .buffer_handle    (buffer_handle),
    .buffer_length    (buffer_length),
    .ack_sequence     (ack_sequence),
    .ack_length_class (ack_length_class),
    .link_state       (link_state),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_kind      (result_kind),
    .frame_sequence   (frame_sequence),
    .frame_handle     (frame_handle),
    .frame_length     (frame_length),
    .last             (last)
  );

  swarq_result_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .buffer_handle    (buffer_handle),
    .buffer_length    (buffer_length),
    .ack_sequence     (ack_sequence),
    .ack_length_class (ack_length_class),
    .link_state       (link_state),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_kind      (result_kind),
    .frame_sequence   (frame_sequence),
    .frame_handle     (frame_handle),
    .frame_length     (frame_length),
    .last             (last),
    .mismatch_count   (mismatch_count),
    .awaited_count    (awaited_count)
  );

  // Length of an idle spell: mostly from the short range, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // The input side idles before roughly four transfers in ten, except during
  // calm stretches, in which events follow back to back.
  function automatic int input_gap();
    if (in_calm > 0) begin
      in_calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      in_calm = $urandom_range(30, 80);
      return 0;
    end
    return ($urandom_range(0, 9) < 4) ? gap_len() : 0;
  endfunction

  // A legal payload length, mostly small, never above the current limit.
  function automatic logic [15:0] short_length();
    int lim;
    lim = int'(cur_cap) - 4;
    return 16'($urandom_range(1, (lim < 48) ? lim : 48));
  endfunction

  // The result side stalls independently of the input side, with its own calm
  // stretches, so that back pressure reaches the input handshake at every
  // point of a frame's life.
  always @(negedge clk) begin
    if (out_calm > 0) begin
      out_calm--;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 2) out_calm = $urandom_range(40, 120);
      else if (pick < 27) stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready && result_kind == KIND_SEND)
      last_sent <= frame_sequence;
  end

  // The watchdog counts cycles in which no transfer happens on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one event and holds it until the transfer happens. Entered and
  // left at a falling edge; valid stays high into the next event when no gap
  // is chosen, so it is never dropped and raised within one time step.
  task automatic post_event(logic [2:0] op, logic [7:0] h, logic [15:0] l,
                            logic [31:0] s, logic [1:0] c, logic [7:0] ls);
    int gap;
    gap = input_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    opcode           <= op;
    buffer_handle    <= h;
    buffer_length    <= l;
    ack_sequence     <= s;
    ack_length_class <= c;
    link_state       <= ls;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted result has been taken, then
  // lets the core settle. Used before register writes, at the end, and now and
  // then in the middle of the traffic.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  task automatic configure(logic open, logic [15:0] tmo, logic [15:0] bko,
                           logic [7:0] lim, logic [15:0] cap);
    settle();
    write_reg(CFG_LINK_OPEN, {15'd0, open});
    write_reg(CFG_RETRY_TIMEOUT, tmo);
    write_reg(CFG_NACK_BACKOFF, bko);
    write_reg(CFG_RETRY_LIMIT, {8'd0, lim});
    write_reg(CFG_MAX_FRAME_PAYLOAD, cap);
    cfg_we  <= 1'b0;
    cur_cap = cap;
  endtask

  // One random event. Traffic is weighted towards a working flow: enqueues,
  // acknowledgements that mostly quote the frame in flight, and ticks that run
  // the retry timer down. Flow resets, closes, spare opcodes and bursts that
  // overfill the descriptor queue are mixed in at a low rate.
  task automatic random_event();
    int          r;
    logic [15:0] l;
    logic [31:0] s;
    logic [1:0]  c;
    r = $urandom_range(0, 99);
    s = ($urandom_range(0, 9) < 8) ? last_sent : 32'($urandom);
    c = ($urandom_range(0, 9) < 9) ? ACK_LEN_FOUR : 2'($urandom_range(0, 2));
    if (r < 30) begin
      case ($urandom_range(0, 19))
        0:       l = 16'($urandom);
        1:       l = cur_cap - 16'd4 + 16'($urandom_range(0, 1));
        2:       l = '0;
        default: l = short_length();
      endcase
      post_event(OP_ENQUEUE, 8'($urandom), l, 32'($urandom),
                 2'($urandom_range(0, 2)), 8'($urandom));
    end else if (r < 32) begin
      repeat (18)
        post_event(OP_ENQUEUE, 8'($urandom), short_length(), 32'($urandom),
                   2'($urandom_range(0, 2)), 8'($urandom));
    end else if (r < 57) begin
      post_event(OP_ACK, 8'($urandom), 16'($urandom), s, c, 8'($urandom));
    end else if (r < 87) begin
      post_event(OP_TICK, 8'($urandom), 16'($urandom), 32'($urandom),
                 2'($urandom_range(0, 2)), 8'($urandom));
    end else if (r < 93) begin
      post_event(OP_NACK, 8'($urandom), 16'($urandom), s,
                 2'($urandom_range(0, 2)), 8'($urandom));
    end else if (r < 96) begin
      post_event(OP_LINK_STATUS, 8'($urandom), 16'($urandom), 32'($urandom),
                 2'($urandom_range(0, 2)),
                 ($urandom_range(0, 3) == 0) ? 8'($urandom) : LINK_CONNECTED);
    end else if (r < 98) begin
      post_event(OP_CLOSE, 8'($urandom), 16'($urandom), 32'($urandom),
                 2'($urandom_range(0, 2)), 8'($urandom));
    end else if (r < 99) begin
      post_event($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, 8'($urandom),
                 16'($urandom), 32'($urandom), 2'($urandom_range(0, 2)), 8'($urandom));
    end else begin
      settle();
    end
  endtask

  task automatic run_phase(logic open, logic [15:0] tmo, logic [15:0] bko,
                           logic [7:0] lim, logic [15:0] cap, int count);
    configure(open, tmo, bko, lim, cap);
    repeat (count) random_event();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Straight out of reset the port is closed: an enqueue is refused and a
    // tick does nothing.
    post_event(OP_ENQUEUE, 8'h11, 16'd10, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_TICK, '0, '0, '0, ACK_LEN_EMPTY, LINK_CONNECTED);

    // Directed walk with the smallest payload limit, so that a single byte is
    // the only length that fits, and a timer of two ticks with one resend.
    configure(1'b1, 16'd2, 16'd1, 8'd1, 16'd5);
    post_event(OP_ENQUEUE, 8'hFF, 16'd1, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_ENQUEUE, 8'h00, 16'd2, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_ENQUEUE, 8'h00, 16'd0, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_ENQUEUE, 8'h00, 16'd1, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    // Acknowledgements of the wrong size or with the wrong number are ignored.
    post_event(OP_ACK, '0, '0, 32'd1, 2'd2, LINK_CONNECTED);
    post_event(OP_ACK, '0, '0, 32'hFFFF_FFFF, ACK_LEN_FOUR, LINK_CONNECTED);
    // An empty NACK re-arms the short backoff; one of another size does not.
    post_event(OP_NACK, '0, '0, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_NACK, '0, '0, 32'd1, 2'd2, LINK_CONNECTED);
    // Expiry resends the frame; the next expiry exceeds the retry limit and the
    // flow is dropped with a failure, taking the queued descriptor with it.
    post_event(OP_TICK, '0, '0, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_TICK, '0, '0, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_TICK, '0, '0, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_ACK, '0, '0, 32'd1, ACK_LEN_FOUR, LINK_CONNECTED);
    post_event(OP_TICK, '0, '0, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    // A fresh frame, a matching four-byte NACK, then a matching ACK.
    post_event(OP_ENQUEUE, 8'h5A, 16'd1, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_NACK, '0, '0, 32'd2, ACK_LEN_FOUR, LINK_CONNECTED);
    post_event(OP_ACK, '0, '0, 32'd2, ACK_LEN_FOUR, LINK_CONNECTED);
    // Link reports: connected leaves the flow alone, anything else clears it.
    post_event(OP_ENQUEUE, 8'hA5, 16'd1, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_LINK_STATUS, '0, '0, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_LINK_STATUS, '0, '0, '0, ACK_LEN_EMPTY, 8'hFC);
    post_event(OP_ENQUEUE, 8'h00, 16'hFFFF, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    // Close restarts numbering at one; spare opcodes pass without effect.
    post_event(OP_CLOSE, '0, '0, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_SPARE_A, '0, '0, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_SPARE_B, '0, '0, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_ENQUEUE, 8'h01, 16'd1, '0, ACK_LEN_EMPTY, LINK_CONNECTED);
    post_event(OP_ACK, '0, '0, 32'd1, ACK_LEN_FOUR, LINK_CONNECTED);

    // Random traffic over a range of settings. The closed phase follows one
    // with frames in flight, so acknowledgements there complete frames without
    // starting the next, which the open phase after it then picks up.
    run_phase(1'b1, 16'd3, 16'd2, 8'd2, 16'd1024, 240);
    run_phase(1'b0, 16'd4, 16'd2, 8'd3, 16'd200, 150);
    run_phase(1'b1, 16'd1, 16'd1, 8'd0, 16'd65535, 210);
    run_phase(1'b1, 16'd65535, 16'd65535, 8'd255, 16'd5, 150);
    run_phase(1'b1, 16'd5, 16'd3, 8'd255, 16'd300, 240);
    run_phase(1'b1, 16'd2, 16'd1, 8'd1, 16'd64, 240);
    run_phase(1'b1, 16'd8, 16'd4, 8'd4, 16'd1024, 250);

    settle();
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
